// ----- design/mesh_face_valence_filter_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the mesh face valence filter
// Concurrent checks on clk, held off while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef MESH_FACE_VALENCE_FILTER_MACROS_SVH
`define MESH_FACE_VALENCE_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MFVF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfvf assertion failed");

// next-cycle implication
`define MFVF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfvf assertion failed");

`else

`define MFVF_ASSERT_IMP(label, ante, cons)
`define MFVF_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- design/mfvf_pkg.sv -----
// ----------------------------------------------------------------------------
// mfvf_pkg
// Shared constants, control/status structs and helpers of the valence filter.
// ----------------------------------------------------------------------------
package mfvf_pkg;

  localparam int VERTEX_CAPACITY = 65536;
  localparam int VERTEX_SLOTS    = 4;
  localparam int COUNT_BITS      = 8;
  localparam int FIELD_SLOTS     = 4;

  localparam int VTX_W  = 16;
  localparam int VCNT_W = 3;
  localparam int THR_W  = 10;
  localparam int SUM_W  = 10;

  localparam int SLOT_LIM   = (VERTEX_SLOTS < FIELD_SLOTS) ? VERTEX_SLOTS : FIELD_SLOTS;
  localparam int STEP_W     = $clog2(SLOT_LIM + 1);
  localparam int SLOT_IDX_W = $clog2(SLOT_LIM);
  localparam int ADDR_W     = $clog2(VERTEX_CAPACITY);
  localparam int ACC_W      = COUNT_BITS + $clog2(SLOT_LIM);

  localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;
  localparam int SUM_MAX   = (1 << SUM_W) - 1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(14);

  localparam logic ACT_COUNT  = 1'b0;
  localparam logic ACT_FILTER = 1'b1;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic              clear;
    logic              load;
    logic              issue;
    logic              proc;
    logic              emit;
    logic [STEP_W-1:0] step;
  } mfvf_cmd_t;

  typedef struct packed {
    logic              clear_last;
    logic              action;
    logic [STEP_W-1:0] nslot;
  } mfvf_stat_t;

  function automatic count_t sat_inc(input count_t c);
    return (32'(c) == COUNT_MAX) ? c : count_t'(32'(c) + 1);
  endfunction

  function automatic logic idx_in_range(input logic [VTX_W-1:0] idx);
    return (32'(idx) < 32'(VERTEX_CAPACITY));
  endfunction

  function automatic logic [SUM_W-1:0] sum_sat(input logic [ACC_W-1:0] acc);
    return (32'(acc) > 32'(SUM_MAX)) ? {SUM_W{1'b1}} : SUM_W'(acc);
  endfunction

endpackage

// ----- design/mfvf_ram.sv -----
// ----------------------------------------------------------------------------
// mfvf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mfvf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read during write to the same address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/mfvf_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfvf_ctrl
// Sequencer: counter clearing sweep, then one polygon at a time, slot by slot.
// ----------------------------------------------------------------------------
`include "mesh_face_valence_filter_macros.svh"

module mfvf_ctrl
  import mfvf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  mfvf_stat_t stat,
  output mfvf_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      step_r  <= '0;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          if (stat.clear_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          step_r <= '0;
          if (start) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step_r == stat.nslot) begin
            state_r <= ST_IDLE;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        default: begin
          state_r <= ST_CLEAR;
        end
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE);

  // step k issues the read of slot k and handles the word of slot k-1
  always_comb begin
    cmd.clear = (state_r == ST_CLEAR);
    cmd.load  = (state_r == ST_IDLE) && start;
    cmd.issue = (state_r == ST_RUN) && (step_r < stat.nslot);
    cmd.proc  = (state_r == ST_RUN) && (step_r != '0);
    cmd.emit  = (state_r == ST_RUN) && (step_r == stat.nslot) && (stat.action == ACT_FILTER);
    cmd.step  = step_r;
  end

  `MFVF_ASSERT_IMP(a_step_range, state_r == ST_RUN, step_r <= stat.nslot)
  `MFVF_ASSERT_IMP(a_emit_filter, cmd.emit, stat.action == ACT_FILTER)
  `MFVF_ASSERT_NXT(a_start_run, state_r == ST_IDLE && start, state_r == ST_RUN && step_r == '0)
  `MFVF_ASSERT_NXT(a_clear_hold, state_r == ST_CLEAR && !stat.clear_last, state_r == ST_CLEAR)

endmodule

// ----- design/mfvf_datapath.sv -----
// ----------------------------------------------------------------------------
// mfvf_datapath
// Vertex use counter memory, read-modify-write with forwarding, sum and keep.
// ----------------------------------------------------------------------------
module mfvf_datapath
  import mfvf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mfvf_cmd_t         cmd,
  output mfvf_stat_t        stat,
  input  logic              in_action,
  input  logic [VCNT_W-1:0] in_vertex_count,
  input  logic [VTX_W-1:0]  in_vertex_a,
  input  logic [VTX_W-1:0]  in_vertex_b,
  input  logic [VTX_W-1:0]  in_vertex_c,
  input  logic [VTX_W-1:0]  in_vertex_d,
  input  logic              cfg_we,
  input  logic [THR_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic              out_keep,
  output logic [SUM_W-1:0]  out_use_sum
);

  logic [VTX_W-1:0]  vtx_in [FIELD_SLOTS];
  logic [VTX_W-1:0]  vtx_r [SLOT_LIM];
  logic              action_r;
  logic [STEP_W-1:0] nslot_r;
  logic [THR_W-1:0]  thr_r;
  logic [ADDR_W-1:0] clr_addr_r;

  logic [ADDR_W-1:0] prc_addr_r;
  logic              prc_ok_r;
  logic              wr_vld_r;
  logic [ADDR_W-1:0] wr_addr_r;
  count_t            wr_data_r;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;

  logic              out_valid_r;
  logic              out_keep_r;
  logic [SUM_W-1:0]  out_sum_r;

  logic [VTX_W-1:0]  iss_idx;
  logic [ADDR_W-1:0] rd_addr;
  count_t            rd_data;
  count_t            cnt_cur;
  count_t            cnt_use;
  logic              cnt_wr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_wa;
  count_t            ram_wd;

  assign vtx_in[0] = in_vertex_a;
  assign vtx_in[1] = in_vertex_b;
  assign vtx_in[2] = in_vertex_c;
  assign vtx_in[3] = in_vertex_d;

  assign stat.clear_last = (clr_addr_r == ADDR_W'(VERTEX_CAPACITY - 1));
  assign stat.action     = action_r;
  assign stat.nslot      = nslot_r;

  assign iss_idx = vtx_r[cmd.step[SLOT_IDX_W-1:0]];
  assign rd_addr = ADDR_W'(iss_idx);

  // word written last cycle is not yet visible at the read port
  assign cnt_cur = (wr_vld_r && (wr_addr_r == prc_addr_r)) ? wr_data_r : rd_data;
  assign cnt_use = prc_ok_r ? cnt_cur : '0;
  assign cnt_wr  = cmd.proc && (action_r == ACT_COUNT) && prc_ok_r;

  assign ram_we = cmd.clear || cnt_wr;
  assign ram_wa = cmd.clear ? clr_addr_r : prc_addr_r;
  assign ram_wd = cmd.clear ? '0 : sat_inc(cnt_cur);

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.proc && (action_r == ACT_FILTER)) begin
      acc_nxt = acc_r + ACC_W'(cnt_use);
    end
  end

  mfvf_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (VERTEX_CAPACITY)
  ) u_cnt_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .re      (cmd.issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      clr_addr_r  <= '0;
      wr_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      wr_vld_r    <= cnt_wr;
      out_valid_r <= cmd.emit;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      nslot_r  <= (32'(in_vertex_count) > SLOT_LIM) ? STEP_W'(SLOT_LIM)
                                                    : STEP_W'(in_vertex_count);
      for (int i = 0; i < SLOT_LIM; i++) begin
        vtx_r[i] <= vtx_in[i];
      end
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
    if (cmd.issue) begin
      prc_addr_r <= rd_addr;
      prc_ok_r   <= idx_in_range(iss_idx);
    end
    if (cnt_wr) begin
      wr_addr_r <= prc_addr_r;
      wr_data_r <= ram_wd;
    end
    if (cmd.emit) begin
      out_keep_r <= (32'(acc_nxt) > 32'(thr_r));
      out_sum_r  <= sum_sat(acc_nxt);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_keep    = out_keep_r;
  assign out_use_sum = out_sum_r;

endmodule

// ----- design/mesh_face_valence_filter.sv -----
// ----------------------------------------------------------------------------
// mesh_face_valence_filter
// Per-vertex use counting and polygon filtering over a counter memory.
// ----------------------------------------------------------------------------
// Usage: present a polygon on the in_ ports and raise start; the word is
// taken at a rising edge with start high and busy low. in_action low counts
// (each used slot bumps its vertex counter, saturating), high filters (sums
// the counters of the used slots and compares with keep_threshold).
// A count word gives no result. A filter word gives one result: out_valid is
// high for exactly one cycle with out_keep and out_use_sum. The receiver
// cannot stall the block, so results must be taken when strobed.
// Timing: busy stays high while the slots of a word are worked through; the
// result strobe comes in the first cycle with busy low, and the next word can
// be taken at the earliest in that same cycle. The pace is set by the counter
// memory: one read per slot, with the write of slot k overlapping the read of
// slot k+1.
// Reset: rst_n low (synchronous) restores keep_threshold to 14 and starts a
// clearing sweep of the counter memory, one entry per cycle over all 65536
// entries, with busy high. cfg_we writes keep_threshold at any time, also
// while clearing; it must only change while no item is in flight.
// ----------------------------------------------------------------------------
module mesh_face_valence_filter
  import mfvf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_action,
  input  logic [VCNT_W-1:0] in_vertex_count,
  input  logic [VTX_W-1:0]  in_vertex_a,
  input  logic [VTX_W-1:0]  in_vertex_b,
  input  logic [VTX_W-1:0]  in_vertex_c,
  input  logic [VTX_W-1:0]  in_vertex_d,
  input  logic              cfg_we,
  input  logic [THR_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic              out_keep,
  output logic [SUM_W-1:0]  out_use_sum
);

  mfvf_cmd_t  cmd;
  mfvf_stat_t stat;

  mfvf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mfvf_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_vertex_count (in_vertex_count),
    .in_vertex_a     (in_vertex_a),
    .in_vertex_b     (in_vertex_b),
    .in_vertex_c     (in_vertex_c),
    .in_vertex_d     (in_vertex_d),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_keep        (out_keep),
    .out_use_sum     (out_use_sum)
  );

endmodule

// ----- tb/tb_mesh_face_valence_filter.sv -----
// ----------------------------------------------------------------------------
// Testbench for mesh_face_valence_filter
// Drives count and filter polygons with random gaps and several threshold
// settings; a scoreboard keeps its own per-vertex counters and checks every
// filter result (keep flag and summed use count) in order.
// ----------------------------------------------------------------------------
module tb_mesh_face_valence_filter;
  import mfvf_pkg::*;

  localparam int CYCLE        = 8;
  localparam int RESET_CYCLES = 9;
  localparam int SETTLE       = 12;
  localparam int PHASE_WORDS  = 275;
  localparam int RUN_LIMIT    = 500000;

  typedef struct packed {
    logic              action;
    logic [VCNT_W-1:0] nverts;
    logic [VTX_W-1:0]  va;
    logic [VTX_W-1:0]  vb;
    logic [VTX_W-1:0]  vc;
    logic [VTX_W-1:0]  vd;
  } polygon_t;

  typedef struct {
    logic             keep;
    logic [SUM_W-1:0] use_sum;
  } face_result_t;

  class valence_scoreboard;
    count_t           use_cnt[VERTEX_CAPACITY];
    logic [THR_W-1:0] threshold;
    face_result_t     pending_q[$];
    int               errors;
    int               checked;
    int               kept;

    function new();
      foreach (use_cnt[i]) use_cnt[i] = '0;
      threshold = THR_RESET;
      errors    = 0;
      checked   = 0;
      kept      = 0;
    endfunction

    function void set_threshold(logic [THR_W-1:0] thr);
      threshold = thr;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    // updates the counters for a count word, queues the result of a filter word
    function void note_word(polygon_t p);
      logic [VTX_W-1:0] slot[FIELD_SLOTS];
      int               n;
      int               total;
      face_result_t     r;
      slot  = '{p.va, p.vb, p.vc, p.vd};
      n     = (int'(p.nverts) > SLOT_LIM) ? SLOT_LIM : int'(p.nverts);
      total = 0;
      for (int s = 0; s < n; s++) begin
        if (int'(slot[s]) < VERTEX_CAPACITY) begin
          if (p.action == ACT_COUNT) begin
            if (int'(use_cnt[slot[s]]) != COUNT_MAX)
              use_cnt[slot[s]] = use_cnt[slot[s]] + 1'b1;
          end else begin
            total += int'(use_cnt[slot[s]]);
          end
        end
      end
      if (p.action == ACT_FILTER) begin
        r.keep    = (total > int'(threshold));
        r.use_sum = (total > SUM_MAX) ? SUM_W'(SUM_MAX) : SUM_W'(total);
        pending_q = {pending_q, r};
      end
    endfunction

    function void check_result(logic keep, logic [SUM_W-1:0] use_sum);
      face_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result: keep %0d use_sum %0d", keep, use_sum);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (keep !== e.keep) begin
        $error("keep mismatch: expected %0d, actual %0d", e.keep, keep);
        errors++;
      end
      if (use_sum !== e.use_sum) begin
        $error("use_sum mismatch: expected %0d, actual %0d", e.use_sum, use_sum);
        errors++;
      end
      if (e.keep) kept++;
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_action;
  logic [VCNT_W-1:0] in_vertex_count;
  logic [VTX_W-1:0]  in_vertex_a;
  logic [VTX_W-1:0]  in_vertex_b;
  logic [VTX_W-1:0]  in_vertex_c;
  logic [VTX_W-1:0]  in_vertex_d;
  logic              cfg_we;
  logic [THR_W-1:0]  cfg_wdata;
  logic              out_valid;
  logic              out_keep;
  logic [SUM_W-1:0]  out_use_sum;

  valence_scoreboard sb = new();
  int                words_sent;
  int                thr_settings;

  mesh_face_valence_filter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_vertex_count (in_vertex_count),
    .in_vertex_a     (in_vertex_a),
    .in_vertex_b     (in_vertex_b),
    .in_vertex_c     (in_vertex_c),
    .in_vertex_d     (in_vertex_d),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_keep        (out_keep),
    .out_use_sum     (out_use_sum)
  );

  initial clk = 1'b0;
  always #(CYCLE / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_keep, out_use_sum);
  end

  function automatic polygon_t make_poly(logic act, int n, int a, int b, int c, int d);
    polygon_t p;
    p.action = act;
    p.nverts = VCNT_W'(n);
    p.va     = VTX_W'(a);
    p.vb     = VTX_W'(b);
    p.vc     = VTX_W'(c);
    p.vd     = VTX_W'(d);
    return p;
  endfunction

  // hot vertices saturate their counters over the run, warm ones sit mid-range
  function automatic logic [VTX_W-1:0] pick_vertex();
    logic [VTX_W-1:0] hot[4];
    int               r;
    hot = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
    r   = $urandom_range(0, 99);
    if (r < 50) return hot[$urandom_range(0, 3)];
    if (r < 80) return VTX_W'($urandom_range(0, 63) * 977 + 100);
    return VTX_W'($urandom_range(0, 65535));
  endfunction

  function automatic polygon_t random_poly();
    polygon_t p;
    p.action = ($urandom_range(0, 99) < 55) ? ACT_COUNT : ACT_FILTER;
    // mostly proper polygons, some with no slots or too many
    if ($urandom_range(0, 99) < 80) p.nverts = VCNT_W'($urandom_range(1, 4));
    else                            p.nverts = VCNT_W'($urandom_range(0, 7));
    p.va = pick_vertex();
    p.vb = pick_vertex();
    p.vc = pick_vertex();
    p.vd = pick_vertex();
    return p;
  endfunction

  // start is left high after the accept; the next call either keeps it up
  // with a new word or drops it for the gap
  task automatic send_word(polygon_t p);
    int gap;
    gap = $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action       <= p.action;
    in_vertex_count <= p.nverts;
    in_vertex_a     <= p.va;
    in_vertex_b     <= p.vb;
    in_vertex_c     <= p.vc;
    in_vertex_d     <= p.vd;
    start           <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_word(p);
    words_sent++;
  endtask

  // drop start, let every result arrive, then let a trailing count word finish
  task automatic go_idle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] thr);
    go_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_threshold(thr);
    thr_settings++;
  endtask

  initial begin
    polygon_t directed_q[$];
    int       phase_thr[7];
    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = ACT_COUNT;
    in_vertex_count = '0;
    in_vertex_a     = '0;
    in_vertex_b     = '0;
    in_vertex_c     = '0;
    in_vertex_d     = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    words_sent      = 0;
    thr_settings    = 1;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // default threshold: empty store, zero slots, repeats, slot count above
    // four, sums either side of the threshold, counting after filtering
    directed_q = {directed_q, make_poly(ACT_FILTER, 1, 0, 0, 0, 0)};
    directed_q = {directed_q, make_poly(ACT_COUNT,  0, 0, 65535, 1, 2)};
    directed_q = {directed_q, make_poly(ACT_FILTER, 0, 0, 0, 0, 0)};
    directed_q = {directed_q, make_poly(ACT_COUNT,  4, 0, 0, 0, 0)};
    directed_q = {directed_q, make_poly(ACT_COUNT,  7, 0, 65535, 1, 2)};
    directed_q = {directed_q, make_poly(ACT_FILTER, 4, 0, 0, 65535, 2)};
    directed_q = {directed_q, make_poly(ACT_FILTER, 7, 0, 0, 0, 0)};
    directed_q = {directed_q, make_poly(ACT_COUNT,  4, 5, 5, 5, 5)};
    directed_q = {directed_q, make_poly(ACT_COUNT,  4, 5, 5, 5, 5)};
    directed_q = {directed_q, make_poly(ACT_COUNT,  4, 5, 5, 5, 5)};
    directed_q = {directed_q, make_poly(ACT_COUNT,  2, 5, 5, 65535, 65535)};
    directed_q = {directed_q, make_poly(ACT_FILTER, 1, 5, 65535, 65535, 65535)};
    directed_q = {directed_q, make_poly(ACT_COUNT,  1, 5, 0, 0, 0)};
    directed_q = {directed_q, make_poly(ACT_FILTER, 1, 5, 0, 0, 0)};
    directed_q = {directed_q, make_poly(ACT_FILTER, 5, 65535, 65535, 65535, 65535)};
    directed_q = {directed_q, make_poly(ACT_COUNT,  3, 65535, 1, 2, 16'h1234)};
    directed_q = {directed_q, make_poly(ACT_FILTER, 3, 65535, 1, 2, 16'h1234)};
    directed_q = {directed_q, make_poly(ACT_FILTER, 6, 5, 5, 0, 65535)};
    foreach (directed_q[i]) send_word(directed_q[i]);

    // negative entries mean a random threshold
    phase_thr = '{0, 1023, 1019, 1020, -1, -1, 500};
    foreach (phase_thr[ph]) begin
      if (phase_thr[ph] < 0) write_threshold(THR_W'($urandom_range(0, 1023)));
      else                   write_threshold(THR_W'(phase_thr[ph]));
      repeat (PHASE_WORDS) send_word(random_poly());
    end

    go_idle();
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    $display("Sent %0d polygons over %0d threshold settings; %0d filter results checked,",
             words_sent, thr_settings, sb.checked);
    $display("%0d of them kept, %0d errors", sb.kept, sb.errors);
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #(CYCLE * RUN_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

endmodule
